FILE: hdl/rmst_pkg.sv
`timescale 1ns / 1ps
// Package for the range-minimum segment tree: shared types, codes and the
// node compare. Used by the tree controller; the node memory does not import it.

package rmst_pkg;

  localparam int unsigned LEAVES_DEF = 256;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned PAY_W      = 32;
  localparam int unsigned NODE_W     = KEY_W + PAY_W;

  localparam logic [KEY_W-1:0] KEY_ALL_ONES = {KEY_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_BUILD  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] position;
    logic [31:0] new_key;
    logic [31:0] new_payload;
    logic [7:0] range_low;
    logic [7:0] range_high;
  } req_t;

  typedef struct packed {
    logic [31:0] min_key;
    logic [31:0] min_payload;
    logic        empty_range;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } node_t;

  // Smaller key wins; on equal keys the right operand wins.
  function automatic node_t pick_node(node_t left, node_t right);
    pick_node = (left.key < right.key) ? left : right;
  endfunction

endpackage

FILE: hdl/rmst_ram.sv
`timescale 1ns / 1ps
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.

module rmst_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hdl/range_min_segment_tree.sv
`timescale 1ns / 1ps
// Range-minimum segment tree over LEAVES slots of key and payload.
// Depends on rmst_pkg and the node memory rmst_ram.
//
// Usage: one request enters on the in channel (in_valid_i, in_stall_o,
// in_req_i) and exactly one response leaves on the out channel (out_valid_o,
// out_stall_i, out_rsp_o). A request is taken at a clock edge with valid high
// and stall low. Requests are handled one at a time.
// Steps, each memory step being one read state and one compare/write state:
//   query:          one step per level walked; an empty range answers with no
//                   memory walk.
//   insert, delete: the leaf write, the path to the root, then a full
//                   range query.
//   build:          a sweep over all leaves, a rebuild of the inner
//                   nodes, then a full range query.
// The single node memory with its one write port serialises these steps.
// After reset the block runs a clearing pass that writes each slot key to its
// own number with payload zero and rebuilds the inner nodes; in_stall_o stays
// high until it is done.
// The response sits in an output register, so a stalled receiver does not
// hold up the next request; only a second finished response waits until the
// first one is taken.

module range_min_segment_tree
  import rmst_pkg::*;
#(
  parameter int unsigned LEAVES = LEAVES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned DEPTH = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = (LEAVES > 2) ? $clog2(LEAVES) : 1;
  localparam int unsigned NW    = AW + 1;
  localparam int unsigned CW    = (NW > 8) ? NW : 8;

  localparam logic [NW-1:0] LEAVES_N   = NW'(LEAVES);
  localparam logic [NW-1:0] DEPTH_N    = NW'(DEPTH);
  localparam logic [AW-1:0] LEAVES_A   = AW'(LEAVES);
  localparam logic [AW-1:0] ROOT_A     = AW'(1);
  localparam logic [AW-1:0] LAST_INNER = AW'(LEAVES - 1);
  localparam logic [IW-1:0] LAST_IDX   = IW'(LEAVES - 1);
  localparam logic [CW-1:0] LEAVES_C   = CW'(LEAVES);
  localparam logic [CW-1:0] TOP_SLOT_C = CW'(LEAVES - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LEAF_RD = 3'd1;
  localparam logic [2:0] S_LEAF_WR = 3'd2;
  localparam logic [2:0] S_NODE_RD = 3'd3;
  localparam logic [2:0] S_NODE_WR = 3'd4;
  localparam logic [2:0] S_Q_RD    = 3'd5;
  localparam logic [2:0] S_Q_WR    = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  logic [2:0]    state_q, state_d;
  logic          init_q, init_d;
  action_e       op_q, op_d;
  logic [31:0]   key_q, key_d;
  logic [31:0]   pay_q, pay_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [AW-1:0] node_q, node_d;
  logic [NW-1:0] l_q, l_d;
  logic [NW-1:0] r_q, r_d;
  logic          accl_v_q, accl_v_d;
  logic          accr_v_q, accr_v_d;
  node_t         accl_q, accl_d;
  node_t         accr_q, accr_d;
  node_t         res_q, res_d;
  logic          empty_q, empty_d;
  logic          out_valid_q, out_valid_d;
  rsp_t          out_rsp_q, out_rsp_d;

  // Memory ports.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  node_t         mem_wdata;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  logic [NODE_W-1:0] mem_rdata_a;
  logic [NODE_W-1:0] mem_rdata_b;
  node_t         rd_a;
  node_t         rd_b;

  // Request decode helpers.
  logic [CW-1:0] pos_c;
  logic [CW-1:0] lo_c;
  logic [CW-1:0] hi_c;
  logic [CW-1:0] hi_sat;

  // Query step helpers.
  logic [NW-1:0] r_dec;
  logic [NW-1:0] l_next;
  logic [NW-1:0] r_next;
  logic [AW-1:0] leaf_addr;

  assign rd_a = node_t'(mem_rdata_a);
  assign rd_b = node_t'(mem_rdata_b);

  assign pos_c  = CW'(in_req_i.position);
  assign lo_c   = CW'(in_req_i.range_low);
  assign hi_c   = CW'(in_req_i.range_high);
  assign hi_sat = (hi_c >= LEAVES_C) ? TOP_SLOT_C : hi_c;

  assign r_dec     = r_q - NW'(1);
  assign leaf_addr = LEAVES_A + AW'(idx_q);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  rmst_ram #(
    .WIDTH (NODE_W),
    .DEPTH (DEPTH)
  ) u_tree_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .rdata_a_o (mem_rdata_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_b_o (mem_rdata_b)
  );

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    op_d        = op_q;
    key_d       = key_q;
    pay_d       = pay_q;
    idx_d       = idx_q;
    node_d      = node_q;
    l_d         = l_q;
    r_d         = r_q;
    accl_v_d    = accl_v_q;
    accr_v_d    = accr_v_q;
    accl_d      = accl_q;
    accr_d      = accr_q;
    res_d       = res_q;
    empty_d     = empty_q;
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_valid_q && out_stall_i;

    mem_we      = 1'b0;
    mem_waddr   = leaf_addr;
    mem_wdata   = '0;
    mem_raddr_a = leaf_addr;
    mem_raddr_b = leaf_addr;
    l_next      = l_q;
    r_next      = r_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_req_i.action;
          key_d   = in_req_i.new_key;
          pay_d   = in_req_i.new_payload;
          empty_d = 1'b0;
          if (in_req_i.action == ACT_QUERY) begin
            if (lo_c > hi_sat) begin
              // Empty range: sentinel answer, no memory walk.
              empty_d = 1'b1;
              res_d   = '{key: KEY_ALL_ONES, payload: '0};
              state_d = S_OUT;
            end else begin
              l_d      = NW'(lo_c) + LEAVES_N;
              r_d      = NW'(hi_sat) + LEAVES_N + NW'(1);
              accl_v_d = 1'b0;
              accr_v_d = 1'b0;
              state_d  = S_Q_RD;
            end
          end else if (in_req_i.action == ACT_BUILD) begin
            idx_d   = '0;
            state_d = S_LEAF_RD;
          end else if (pos_c < LEAVES_C) begin
            idx_d   = IW'(in_req_i.position);
            state_d = S_LEAF_RD;
          end else begin
            // Slot outside the store: nothing changes, report the minimum.
            l_d      = LEAVES_N;
            r_d      = DEPTH_N;
            accl_v_d = 1'b0;
            accr_v_d = 1'b0;
            state_d  = S_Q_RD;
          end
        end
      end

      S_LEAF_RD: begin
        mem_raddr_a = leaf_addr;
        state_d     = S_LEAF_WR;
      end

      S_LEAF_WR: begin
        mem_we    = 1'b1;
        mem_waddr = leaf_addr;
        if (init_q) begin
          mem_wdata = '{key: 32'(idx_q), payload: '0};
        end else if (op_q == ACT_INSERT) begin
          mem_wdata = '{key: key_q, payload: pay_q};
        end else if (op_q == ACT_DELETE) begin
          mem_wdata = '{key: KEY_ALL_ONES, payload: rd_a.payload};
        end else begin
          mem_wdata = '{key: 32'(idx_q), payload: rd_a.payload};
        end
        if (init_q || (op_q == ACT_BUILD)) begin
          if (idx_q == LAST_IDX) begin
            node_d  = LAST_INNER;
            state_d = S_NODE_RD;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_LEAF_RD;
          end
        end else begin
          node_d  = leaf_addr >> 1;
          state_d = S_NODE_RD;
        end
      end

      S_NODE_RD: begin
        mem_raddr_a = {node_q[AW-2:0], 1'b0};
        mem_raddr_b = {node_q[AW-2:0], 1'b1};
        state_d     = S_NODE_WR;
      end

      S_NODE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = node_q;
        mem_wdata = pick_node(rd_a, rd_b);
        if (node_q == ROOT_A) begin
          if (init_q) begin
            init_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            l_d      = LEAVES_N;
            r_d      = DEPTH_N;
            accl_v_d = 1'b0;
            accr_v_d = 1'b0;
            state_d  = S_Q_RD;
          end
        end else begin
          // A full rebuild sweeps downward; a single update climbs its path.
          if (init_q || (op_q == ACT_BUILD)) begin
            node_d = node_q - AW'(1);
          end else begin
            node_d = node_q >> 1;
          end
          state_d = S_NODE_RD;
        end
      end

      S_Q_RD: begin
        mem_raddr_a = l_q[AW-1:0];
        mem_raddr_b = r_dec[AW-1:0];
        state_d     = S_Q_WR;
      end

      S_Q_WR: begin
        if (l_q[0]) begin
          accl_d   = accl_v_q ? pick_node(accl_q, rd_a) : rd_a;
          accl_v_d = 1'b1;
          l_next   = l_q + NW'(1);
        end
        if (r_q[0]) begin
          accr_d   = accr_v_q ? pick_node(rd_b, accr_q) : rd_b;
          accr_v_d = 1'b1;
          r_next   = r_dec;
        end
        l_d = l_next >> 1;
        r_d = r_next >> 1;
        if ((l_next >> 1) < (r_next >> 1)) begin
          state_d = S_Q_RD;
        end else begin
          if (!accl_v_d) begin
            res_d = accr_d;
          end else if (!accr_v_d) begin
            res_d = accl_d;
          end else begin
            res_d = pick_node(accl_d, accr_d);
          end
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_rsp_d   = '{min_key: res_q.key, min_payload: res_q.payload,
                          empty_range: empty_q};
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LEAF_RD;
      init_q      <= 1'b1;
      op_q        <= ACT_BUILD;
      idx_q       <= '0;
      node_q      <= '0;
      l_q         <= '0;
      r_q         <= '0;
      accl_v_q    <= 1'b0;
      accr_v_q    <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      op_q        <= op_d;
      idx_q       <= idx_d;
      node_q      <= node_d;
      l_q         <= l_d;
      r_q         <= r_d;
      accl_v_q    <= accl_v_d;
      accr_v_q    <= accr_v_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    pay_q     <= pay_d;
    accl_q    <= accl_d;
    accr_q    <= accr_d;
    res_q     <= res_d;
    out_rsp_q <= out_rsp_d;
  end

endmodule
